@@ design/tmad_pkg.sv @@
// Shared widths, reset values and configuration register indexes for the
// trimmed-mean ADC diagnostic block. No dependencies.
package tmad_pkg;

    localparam int CH_W      = 4;   // channel tag width
    localparam int RAW_W     = 12;  // raw converter code width
    localparam int MV_W      = 13;  // millivolt value width
    localparam int CFG_W     = 13;  // widest configuration register
    localparam int CFG_IDX_W = 2;   // configuration index width
    localparam int PROD_W    = 26;  // (code + 1) * ref_mv

    localparam int SAMPLES_PER_WINDOW_DEF = 5;
    localparam int NUM_CHANNELS_DEF       = 16;

    localparam int               MV_MAX_INT    = 8191;
    localparam logic [MV_W-1:0]  MV_MAX        = 13'd8191;
    localparam logic [12:0]      FULL_SCALE_12 = 13'd4095;
    localparam logic [10:0]      FULL_SCALE_10 = 11'd1023;

    localparam logic [12:0] REF_MV_RST     = 13'd3300;
    localparam logic        TWELVE_BIT_RST = 1'b1;
    localparam logic [12:0] SHORT_THR_RST  = 13'd1100;
    localparam logic [12:0] OPEN_THR_RST   = 13'd110;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REF_MV     = 2'd0,
        CFG_TWELVE_BIT = 2'd1,
        CFG_SHORT_THR  = 2'd2,
        CFG_OPEN_THR   = 2'd3
    } t_cfg_idx;

endpackage

@@ design/trimmed_mean_adc_diag_top.sv @@
// Trimmed-mean ADC diagnostic: converts tagged samples to millivolts, keeps a
// per-channel window and emits the trimmed mean with short/open flags.
// Depends on tmad_pkg.
// A window-completing item passes through the input register, multiply,
// divide by full scale, window update, subtract, and reciprocal multiply and
// threshold compare into the output register.
// Throughput: one item per cycle; stages hold only while the output is stalled.
// Reset (synchronous, active low) empties the pipeline, zeroes every channel's
// window count and loads the configuration registers with their defaults.
module trimmed_mean_adc_diag_top #(
    parameter int SAMPLES_PER_WINDOW = tmad_pkg::SAMPLES_PER_WINDOW_DEF,
    parameter int NUM_CHANNELS       = tmad_pkg::NUM_CHANNELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [tmad_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tmad_pkg::CFG_W-1:0]     i_cfg_data,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [tmad_pkg::CH_W-1:0]      i_channel,
    input  logic [tmad_pkg::RAW_W-1:0]     i_raw_sample,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [tmad_pkg::CH_W-1:0]      o_out_channel,
    output logic [tmad_pkg::MV_W-1:0]      o_mean_mv,
    output logic                           o_short_detected,
    output logic                           o_open_detected
);

    localparam int CHW      = tmad_pkg::CH_W;
    localparam int MVW      = tmad_pkg::MV_W;
    localparam int PRW      = tmad_pkg::PROD_W;
    localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CNT_W    = $clog2(SAMPLES_PER_WINDOW);
    localparam int SUM_W    = $clog2(SAMPLES_PER_WINDOW * tmad_pkg::MV_MAX_INT + 1);
    localparam int DIV_K    = SAMPLES_PER_WINDOW - 2;
    localparam int REC_SH   = SUM_W + 3;
    localparam int REC_W    = REC_SH + 1;
    localparam int QP_W     = SUM_W + REC_W;

    localparam logic [CHW:0]       CH_LIMIT = (CHW + 1)'(NUM_CHANNELS);
    localparam logic [CNT_W-1:0]   LAST_CNT = CNT_W'(SAMPLES_PER_WINDOW - 1);
    localparam logic [REC_W-1:0]   REC_K    = REC_W'((2 ** REC_SH + DIV_K - 1) / DIV_K);

    // configuration registers
    logic [12:0] r_ref_mv;
    logic        r_twelve_bit;
    logic [12:0] r_short_thr;
    logic [12:0] r_open_thr;

    // pipeline registers
    logic                  r_v1, r_v2, r_v3, r_v4, r_v5, r_ov;
    logic [CHW-1:0]        r_ch1, r_ch2, r_ch3, r_ch4, r_ch5, r_och;
    logic [tmad_pkg::RAW_W-1:0] r_raw1;
    logic [PRW-1:0]        r_prod2;
    logic [MVW-1:0]        r_mv3;
    logic [SUM_W-1:0]      r_sum4;
    logic [MVW-1:0]        r_min4, r_max4;
    logic [SUM_W-1:0]      r_diff5;
    logic [MVW-1:0]        r_omean;
    logic                  r_oshort, r_oopen;

    // per-channel window state
    logic [CNT_W-1:0]      r_cnt  [NUM_CHANNELS];
    logic [MVW-1:0]        r_wmin [NUM_CHANNELS];
    logic [MVW-1:0]        r_wmax [NUM_CHANNELS];
    logic [SUM_W-1:0]      r_wsum [NUM_CHANNELS];

    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;
    logic in_acc, upd;

    // next values
    logic [12:0]       n_code;
    logic [PRW-1:0]    n_prod;
    logic [13:0]       a12;
    logic [14:0]       s12;
    logic [12:0]       t12;
    logic [14:0]       q12;
    logic [15:0]       a10;
    logic [16:0]       s10;
    logic [10:0]       t10;
    logic [16:0]       q10;
    logic [16:0]       q_any;
    logic [MVW-1:0]    n_mv;
    logic [CH_IDX_W-1:0] idx;
    logic              first, last;
    logic [MVW-1:0]    n_min, n_max;
    logic [SUM_W-1:0]  n_sum;
    logic [SUM_W-1:0]  n_diff;
    logic [QP_W-1:0]   qprod;
    logic [MVW-1:0]    n_mean;

    // ready chain: a stage takes a new item when empty or when it moves on
    assign rdy_out    = !r_ov || !i_out_stall;
    assign rdy5       = !r_v5 || rdy_out;
    assign rdy4       = !r_v4 || rdy5;
    assign rdy3       = !r_v3 || rdy4;
    assign rdy2       = !r_v2 || rdy3;
    assign rdy1       = !r_v1 || rdy2;
    assign o_in_stall = !rdy1;
    assign in_acc     = i_in_valid && rdy1;
    assign upd        = r_v3 && rdy4;

    // stage 1 -> 2: (code + 1) * ref_mv
    always_comb begin
        if (r_twelve_bit) begin
            n_code = {1'b0, r_raw1};
        end else begin
            n_code = {3'b0, r_raw1[9:0]};
        end
        n_prod = PRW'(n_code + 13'd1) * PRW'(r_ref_mv);
    end

    // stage 2 -> 3: divide by 2^k - 1 as x = a*2^k + b, x/(2^k-1) = a + (a+b)/(2^k-1)
    always_comb begin
        a12   = r_prod2[25:12];
        s12   = {1'b0, a12} + {3'b0, r_prod2[11:0]};
        t12   = {10'b0, s12[14:12]} + {1'b0, s12[11:0]};
        q12   = {1'b0, a12} + {12'b0, s12[14:12]}
              + {14'b0, (t12 >= tmad_pkg::FULL_SCALE_12)};
        a10   = r_prod2[25:10];
        s10   = {1'b0, a10} + {7'b0, r_prod2[9:0]};
        t10   = {4'b0, s10[16:10]} + {1'b0, s10[9:0]};
        q10   = {1'b0, a10} + {10'b0, s10[16:10]}
              + {16'b0, (t10 >= tmad_pkg::FULL_SCALE_10)};
        q_any = r_twelve_bit ? {2'b0, q12} : q10;
        // saturate when ref_mv is set beyond its normal range
        if (q_any > {4'b0, tmad_pkg::MV_MAX}) begin
            n_mv = tmad_pkg::MV_MAX;
        end else begin
            n_mv = q_any[MVW-1:0];
        end
    end

    // stage 3: window update on the item's channel
    always_comb begin
        idx   = r_ch3[CH_IDX_W-1:0];
        first = (r_cnt[idx] == '0);
        last  = (r_cnt[idx] == LAST_CNT);
        if (first) begin
            n_min = r_mv3;
            n_max = r_mv3;
            n_sum = SUM_W'(r_mv3);
        end else begin
            n_min = (r_mv3 < r_wmin[idx]) ? r_mv3 : r_wmin[idx];
            n_max = (r_mv3 > r_wmax[idx]) ? r_mv3 : r_wmax[idx];
            n_sum = r_wsum[idx] + SUM_W'(r_mv3);
        end
    end

    // stage 4 -> 5: drop the extremes
    assign n_diff = r_sum4 - SUM_W'(r_min4) - SUM_W'(r_max4);

    // stage 5 -> out: divide by N-2 through a rounded-up reciprocal
    assign qprod  = QP_W'(r_diff5) * QP_W'(REC_K);
    assign n_mean = qprod[REC_SH +: MVW];

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_v4         <= 1'b0;
            r_v5         <= 1'b0;
            r_ov         <= 1'b0;
            r_ref_mv     <= tmad_pkg::REF_MV_RST;
            r_twelve_bit <= tmad_pkg::TWELVE_BIT_RST;
            r_short_thr  <= tmad_pkg::SHORT_THR_RST;
            r_open_thr   <= tmad_pkg::OPEN_THR_RST;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            // drop items for channels that do not exist
            if (rdy1) r_v1 <= in_acc && ({1'b0, i_channel} < CH_LIMIT);
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3 && last;
            if (rdy5) r_v5 <= r_v4;
            if (rdy_out) r_ov <= r_v5;
            if (upd) begin
                r_cnt[idx] <= last ? '0 : r_cnt[idx] + CNT_W'(1);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tmad_pkg::CFG_REF_MV:     r_ref_mv     <= i_cfg_data;
                    tmad_pkg::CFG_TWELVE_BIT: r_twelve_bit <= i_cfg_data[0];
                    tmad_pkg::CFG_SHORT_THR:  r_short_thr  <= i_cfg_data;
                    tmad_pkg::CFG_OPEN_THR:   r_open_thr   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_ch1  <= i_channel;
            r_raw1 <= i_raw_sample;
        end
        if (rdy2) begin
            r_ch2   <= r_ch1;
            r_prod2 <= n_prod;
        end
        if (rdy3) begin
            r_ch3 <= r_ch2;
            r_mv3 <= n_mv;
        end
        if (upd) begin
            r_wmin[idx] <= n_min;
            r_wmax[idx] <= n_max;
            r_wsum[idx] <= n_sum;
        end
        if (rdy4) begin
            r_ch4  <= r_ch3;
            r_sum4 <= n_sum;
            r_min4 <= n_min;
            r_max4 <= n_max;
        end
        if (rdy5) begin
            r_ch5   <= r_ch4;
            r_diff5 <= n_diff;
        end
        if (rdy_out) begin
            r_och    <= r_ch5;
            r_omean  <= n_mean;
            r_oshort <= (n_mean > r_short_thr);
            r_oopen  <= (n_mean < r_open_thr);
        end
    end

    assign o_out_valid      = r_ov;
    assign o_out_channel    = r_och;
    assign o_mean_mv        = r_omean;
    assign o_short_detected = r_oshort;
    assign o_open_detected  = r_oopen;

endmodule

@@ design/tmad_checker.sv @@
// Port-level checks for the trimmed-mean ADC diagnostic, bound to the top level.
// Depends on tmad_pkg and trimmed_mean_adc_diag_top.
module tmad_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tmad_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tmad_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           o_in_stall,
    input  logic                           o_out_valid,
    input  logic                           i_out_stall,
    input  logic [tmad_pkg::CH_W-1:0]      o_out_channel,
    input  logic [tmad_pkg::MV_W-1:0]      o_mean_mv,
    input  logic                           o_short_detected,
    input  logic                           o_open_detected
);

    logic [12:0] r_short_thr;
    logic [12:0] r_open_thr;

    // shadow the threshold registers from the write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_thr <= tmad_pkg::SHORT_THR_RST;
            r_open_thr  <= tmad_pkg::OPEN_THR_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == tmad_pkg::CFG_SHORT_THR) r_short_thr <= i_cfg_data;
            if (i_cfg_index == tmad_pkg::CFG_OPEN_THR)  r_open_thr  <= i_cfg_data;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_out_channel) && $stable(o_mean_mv) &&
            $stable(o_short_detected) && $stable(o_open_detected))
        else $error("stalled result changed");

    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while the result side is free");

    a_short_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_short_detected == (o_mean_mv > r_short_thr))
        else $error("short flag disagrees with threshold");

    a_open_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_open_detected == (o_mean_mv < r_open_thr))
        else $error("open flag disagrees with threshold");

endmodule

bind trimmed_mean_adc_diag_top tmad_checker u_tmad_checker (.*);
